>>> sv/shape_overlap_test_defines.svh
// Assertion macros for the shape overlap test block.
`ifndef SHAPE_OVERLAP_TEST_DEFINES_SVH
`define SHAPE_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SOT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sot assertion failed");

// Next-cycle implication, checked outside reset.
`define SOT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sot assertion failed");

`endif

>>> sv/sot_pkg.sv
// Package: widths and pair kind codes for the shape overlap test.
`default_nettype none

package sot_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 2 * COORD_BITS;
    localparam int CTR_W      = COORD_BITS + 1;
    localparam int DIF_W      = COORD_BITS + 3;
    localparam int MAG_W      = COORD_BITS + 2;
    localparam int RAD_W      = COORD_BITS + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int RSQ_W      = 2 * RAD_W;
    localparam int SUM_W      = SQ_W + 1;

    typedef enum logic [1:0] {
        KIND_CC = 2'd0,
        KIND_CR = 2'd1,
        KIND_RC = 2'd2,
        KIND_RR = 2'd3
    } t_pair_kind;

    typedef logic signed [CTR_W-1:0] t_ctr;
    typedef logic signed [DIF_W-1:0] t_dif;

endpackage

`default_nettype wire

>>> sv/shape_overlap_test.sv
// Pipeline: five register stages lie between the accepting edge and the valid hit beat.
// Throughput: one pair per cycle while o_stall is low; stages fill bubbles while the output beat is stalled.
// Stages: centre sums, shape selection and box bounds, clamp, squares, compare.
// Reset: synchronous active low i_rst_n clears all stage valid bits; payload is not reset.
// No kept state between pairs.
`default_nettype none

`include "shape_overlap_test_defines.svh"

module shape_overlap_test (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [1:0]                      i_pair_kind,
    input  wire  [sot_pkg::FIELD_W-1:0]     i_a_position,
    input  wire  [sot_pkg::FIELD_W-1:0]     i_a_offset,
    input  wire  [sot_pkg::FIELD_W-1:0]     i_a_extent,
    input  wire  [sot_pkg::FIELD_W-1:0]     i_b_position,
    input  wire  [sot_pkg::FIELD_W-1:0]     i_b_offset,
    input  wire  [sot_pkg::FIELD_W-1:0]     i_b_extent,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic                            o_hit
);
    import sot_pkg::*;

    logic w_en1, w_en2, w_en3, w_en4, w_en5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: collider centres
    t_pair_kind              r_kind1;
    t_ctr                    r_ax1, r_ay1, r_bx1, r_by1;
    logic [FIELD_W-1:0]      r_ae1, r_be1;
    t_ctr                    n_ax1, n_ay1, n_bx1, n_by1;

    // stage 2: circle, box bounds, rect-rect result
    t_dif                    r_cx2, r_cy2, r_xlo2, r_xhi2, r_ylo2, r_yhi2;
    logic [RAD_W-1:0]        r_rad2;
    logic                    r_rr2, r_rrhit2;
    t_dif                    n_cx2, n_cy2, n_xlo2, n_xhi2, n_ylo2, n_yhi2;
    logic [RAD_W-1:0]        n_rad2;
    logic                    n_rr2, n_rrhit2;

    // stage 3: distance magnitudes to clamped point
    logic [MAG_W-1:0]        r_dx3, r_dy3;
    logic [RAD_W-1:0]        r_rad3;
    logic                    r_rr3, r_rrhit3;
    logic [MAG_W-1:0]        n_dx3, n_dy3;

    // stage 4: squares
    logic [SQ_W-1:0]         r_dxsq4, r_dysq4;
    logic [RSQ_W-1:0]        r_rsq4;
    logic                    r_rr4, r_rrhit4;

    // stage 5: result
    logic                    r_hit5;
    logic                    n_hit5;

    assign w_en5   = !r_v5 || !i_stall;
    assign w_en4   = !r_v4 || w_en5;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v5;
    assign o_hit   = r_hit5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= r_v4;
        end
    end

    // stage 1
    always_comb begin
        n_ax1 = CTR_W'($signed(i_a_position[FIELD_W-1:COORD_BITS]))
              + CTR_W'($signed(i_a_offset[FIELD_W-1:COORD_BITS]));
        n_ay1 = CTR_W'($signed(i_a_position[COORD_BITS-1:0]))
              + CTR_W'($signed(i_a_offset[COORD_BITS-1:0]));
        n_bx1 = CTR_W'($signed(i_b_position[FIELD_W-1:COORD_BITS]))
              + CTR_W'($signed(i_b_offset[FIELD_W-1:COORD_BITS]));
        n_by1 = CTR_W'($signed(i_b_position[COORD_BITS-1:0]))
              + CTR_W'($signed(i_b_offset[COORD_BITS-1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_kind1 <= t_pair_kind'(i_pair_kind);
            r_ax1   <= n_ax1;
            r_ay1   <= n_ay1;
            r_bx1   <= n_bx1;
            r_by1   <= n_by1;
            r_ae1   <= i_a_extent;
            r_be1   <= i_b_extent;
        end
    end

    // stage 2
    always_comb begin
        t_dif ax, ay, bx, by, aw, ah, bw, bh;
        logic [RAD_W-1:0] ra, rb;
        ax = DIF_W'(r_ax1);
        ay = DIF_W'(r_ay1);
        bx = DIF_W'(r_bx1);
        by = DIF_W'(r_by1);
        aw = DIF_W'($signed({1'b0, r_ae1[FIELD_W-1:COORD_BITS]}));
        ah = DIF_W'($signed({1'b0, r_ae1[COORD_BITS-1:0]}));
        bw = DIF_W'($signed({1'b0, r_be1[FIELD_W-1:COORD_BITS]}));
        bh = DIF_W'($signed({1'b0, r_be1[COORD_BITS-1:0]}));
        ra = RAD_W'(r_ae1[COORD_BITS-1:0]);
        rb = RAD_W'(r_be1[COORD_BITS-1:0]);

        n_rr2    = 1'b0;
        n_rrhit2 = 1'b0;
        n_cx2    = ax;
        n_cy2    = ay;
        n_xlo2   = bx;
        n_xhi2   = bx;
        n_ylo2   = by;
        n_yhi2   = by;
        n_rad2   = ra + rb;
        case (r_kind1)
            KIND_CC: begin
                n_rad2 = ra + rb;
            end
            KIND_CR: begin
                n_rad2 = ra;
                n_xlo2 = bx - bw;
                n_xhi2 = bx + bw;
                n_ylo2 = by - bh;
                n_yhi2 = by + bh;
            end
            KIND_RC: begin
                n_rad2 = rb;
                n_cx2  = bx;
                n_cy2  = by;
                n_xlo2 = ax - aw;
                n_xhi2 = ax + aw;
                n_ylo2 = ay - ah;
                n_yhi2 = ay + ah;
            end
            KIND_RR: begin
                n_rr2    = 1'b1;
                n_rrhit2 = (ax - aw < bx + bw) && (ax + aw > bx - bw)
                        && (ay - ah < by + bh) && (ay + ah > by - bh);
            end
            default: begin
                n_rr2 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_cx2    <= n_cx2;
            r_cy2    <= n_cy2;
            r_xlo2   <= n_xlo2;
            r_xhi2   <= n_xhi2;
            r_ylo2   <= n_ylo2;
            r_yhi2   <= n_yhi2;
            r_rad2   <= n_rad2;
            r_rr2    <= n_rr2;
            r_rrhit2 <= n_rrhit2;
        end
    end

    // stage 3: clamp centre to box, take magnitude
    always_comb begin
        t_dif tx, ty, px, py, dx, dy;
        tx = (r_cx2 < r_xhi2) ? r_cx2 : r_xhi2;
        px = (tx > r_xlo2) ? tx : r_xlo2;
        ty = (r_cy2 < r_yhi2) ? r_cy2 : r_yhi2;
        py = (ty > r_ylo2) ? ty : r_ylo2;
        dx = r_cx2 - px;
        dy = r_cy2 - py;
        n_dx3 = dx[DIF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        n_dy3 = dy[DIF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_dx3    <= n_dx3;
            r_dy3    <= n_dy3;
            r_rad3   <= r_rad2;
            r_rr3    <= r_rr2;
            r_rrhit3 <= r_rrhit2;
        end
    end

    // stage 4
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_dxsq4  <= SQ_W'(r_dx3) * SQ_W'(r_dx3);
            r_dysq4  <= SQ_W'(r_dy3) * SQ_W'(r_dy3);
            r_rsq4   <= RSQ_W'(r_rad3) * RSQ_W'(r_rad3);
            r_rr4    <= r_rr3;
            r_rrhit4 <= r_rrhit3;
        end
    end

    // stage 5
    always_comb begin
        logic [SUM_W-1:0] dsq;
        dsq    = SUM_W'(r_dxsq4) + SUM_W'(r_dysq4);
        n_hit5 = r_rr4 ? r_rrhit4 : (dsq < SUM_W'(r_rsq4));
    end

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r_hit5 <= n_hit5;
        end
    end

    `SOT_ASSERT_NOW(a_stall_only_when_full, o_stall, o_valid && i_stall)
    `SOT_ASSERT_NEXT(a_sq_stage_holds, r_v4 && !w_en4, r_v4 && $stable(r_dxsq4) && $stable(r_rsq4))
    `SOT_ASSERT_NOW(a_rrhit_only_rect, r_v2 && !r_rr2, !r_rrhit2)

endmodule

`default_nettype wire
